FILE: hdl/ypfv_pkg.sv
// ypfv_pkg: shared constants, types and arithmetic helpers for the yaw/pitch
// forward vector block. No dependencies; every other file imports it.
`default_nettype none

package ypfv_pkg;

    localparam int OUT_FRAC_BITS   = 14;
    localparam int CORDIC_STEPS    = 16;

    localparam int FIELD_W         = 16;
    localparam int GAIN_W          = 16;
    localparam int YAW_W           = 16;
    localparam int PITCH_W         = 15;
    localparam int STEP_SHIFT      = 9;
    localparam int STEP_W          = 24;
    localparam int ACC_W           = 24;
    localparam int PROD_W          = FIELD_W + GAIN_W + 1;

    localparam int YAW_TURN        = 46080;
    localparam int HALF_TURN       = 23040;
    localparam int QUARTER_TURN    = 11520;
    localparam int PITCH_LIMIT     = 11392;
    localparam int REDUCE_STEPS    = 8;
    localparam int YAW_BIAS        = YAW_TURN * (1 << (REDUCE_STEPS - 1));
    localparam int GAIN_RESET      = 7680;

    localparam int CW              = 32;
    localparam int ZW              = 26;
    localparam int Z_SHIFT         = 9;
    localparam int CNT_W           = $clog2(CORDIC_STEPS);
    localparam int ATAN_W          = 23;
    localparam int CORDIC_GAIN_Q30 = 652032874;

    localparam int MUL_W           = 2 * CW;
    localparam int Q60_SHIFT       = 60 - OUT_FRAC_BITS;
    localparam int Q30_SHIFT       = 30 - OUT_FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_COR_YAW,
        ST_COR_PITCH,
        ST_PROD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [CW-1:0] sin_v;
        logic signed [CW-1:0] cos_v;
    } sincos_t;

    typedef struct packed {
        logic [FIELD_W-1:0] fwd_z;
        logic [FIELD_W-1:0] fwd_y;
        logic [FIELD_W-1:0] fwd_x;
    } fwd_vec_t;

    // atan(2^-k) in q16 degrees
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] k);
        logic [ATAN_W-1:0] r;
        case (k)
            5'd0:    r = 23'd2949120;
            5'd1:    r = 23'd1740967;
            5'd2:    r = 23'd919879;
            5'd3:    r = 23'd466945;
            5'd4:    r = 23'd234379;
            5'd5:    r = 23'd117304;
            5'd6:    r = 23'd58666;
            5'd7:    r = 23'd29335;
            5'd8:    r = 23'd14668;
            5'd9:    r = 23'd7334;
            5'd10:   r = 23'd3667;
            5'd11:   r = 23'd1833;
            5'd12:   r = 23'd917;
            5'd13:   r = 23'd458;
            5'd14:   r = 23'd229;
            5'd15:   r = 23'd115;
            5'd16:   r = 23'd57;
            5'd17:   r = 23'd29;
            5'd18:   r = 23'd14;
            5'd19:   r = 23'd7;
            5'd20:   r = 23'd4;
            5'd21:   r = 23'd2;
            5'd22:   r = 23'd1;
            default: r = 23'd0;
        endcase
        return r;
    endfunction

    // round half up, floor shift, clamp to +/-1.0 and keep the low field bits
    function automatic logic [FIELD_W-1:0] round_clamp(input logic signed [MUL_W-1:0] v,
                                                       input int sh);
        logic signed [MUL_W-1:0] r;
        logic signed [MUL_W-1:0] lim;
        lim = MUL_W'(64'sd1 <<< OUT_FRAC_BITS);
        r   = v;
        if (sh > 0)
        begin
            r = (v + (MUL_W'(64'sd1) <<< (sh - 1))) >>> sh;
        end
        if (r > lim)
        begin
            r = lim;
        end
        if (r < -lim)
        begin
            r = -lim;
        end
        return r[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ypfv_angle.sv
// ypfv_angle: stored yaw/pitch angles, gain scaling of the deltas and the
// yaw wrap by shift-and-subtract over several cycles. Depends on ypfv_pkg.
`default_nettype none

module ypfv_angle
    import ypfv_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [FIELD_W-1:0] delta_horizontal,
    input  wire logic signed [FIELD_W-1:0] delta_vertical,
    input  wire logic        [GAIN_W-1:0]  rotation_gain,
    output logic                           done,
    output logic signed [FIELD_W-1:0]      yaw_signed,
    output logic signed [FIELD_W-1:0]      pitch_signed
);

    localparam int KW = $clog2(REDUCE_STEPS);
    localparam logic signed [STEP_W:0] PITCH_HI = (STEP_W+1)'(PITCH_LIMIT);
    localparam logic signed [STEP_W:0] PITCH_LO = -PITCH_HI;

    logic        [YAW_W-1:0]   yaw_reg, yaw_next;
    logic signed [PITCH_W-1:0] pitch_reg, pitch_next;
    logic        [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [FIELD_W-1:0] dv_reg, dv_next;
    logic        [KW-1:0]      k_reg, k_next;
    logic                      busy_reg, busy_next;
    logic                      pend_reg, pend_next;
    logic                      done_reg, done_next;

    logic signed [FIELD_W-1:0] mul_a;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [PROD_W-1:0]  mul_prod;
    logic signed [STEP_W-1:0]  step;
    logic signed [ACC_W:0]     acc_sum;
    logic signed [STEP_W:0]    pitch_sum;
    logic        [ACC_W-1:0]   turn_k;
    logic        [ACC_W-1:0]   acc_sub;
    logic signed [YAW_W:0]     yaw_wide;

    // one multiplier: horizontal delta at start, vertical delta next cycle
    assign mul_a    = busy_reg ? dv_reg : delta_horizontal;
    assign gain_s   = $signed({1'b0, rotation_gain});
    assign mul_prod = mul_a * gain_s;
    assign step     = STEP_W'((mul_prod + PROD_W'(1 << (STEP_SHIFT - 1))) >>> STEP_SHIFT);

    assign acc_sum   = (ACC_W+1)'($signed({1'b0, yaw_reg})) + (ACC_W+1)'(step)
                     + (ACC_W+1)'(YAW_BIAS);
    assign pitch_sum = (STEP_W+1)'(pitch_reg) + (STEP_W+1)'(step);
    assign turn_k    = ACC_W'(YAW_TURN) << k_reg;
    assign acc_sub   = (acc_reg >= turn_k) ? (acc_reg - turn_k) : acc_reg;

    always_comb
    begin
        yaw_next   = yaw_reg;
        pitch_next = pitch_reg;
        acc_next   = acc_reg;
        dv_next    = dv_reg;
        k_next     = k_reg;
        busy_next  = busy_reg;
        pend_next  = pend_reg;
        done_next  = 1'b0;
        if (start)
        begin
            acc_next  = acc_sum[ACC_W-1:0];
            dv_next   = delta_vertical;
            k_next    = KW'(REDUCE_STEPS - 1);
            busy_next = 1'b1;
            pend_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (pend_reg)
            begin
                pend_next = 1'b0;
                if (pitch_sum > PITCH_HI)
                begin
                    pitch_next = PITCH_W'(PITCH_HI);
                end
                else if (pitch_sum < PITCH_LO)
                begin
                    pitch_next = PITCH_W'(PITCH_LO);
                end
                else
                begin
                    pitch_next = PITCH_W'(pitch_sum);
                end
            end
            acc_next = acc_sub;
            if (k_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                yaw_next  = acc_sub[YAW_W-1:0];
            end
            else
            begin
                k_next = k_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg   <= '0;
            pitch_reg <= '0;
            k_reg     <= '0;
            busy_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            yaw_reg   <= yaw_next;
            pitch_reg <= pitch_next;
            k_reg     <= k_next;
            busy_reg  <= busy_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        dv_reg  <= dv_next;
    end

    // yaw shown as -180..180 degrees for the cordic
    assign yaw_wide     = (yaw_reg >= YAW_W'(HALF_TURN))
                        ? ($signed({1'b0, yaw_reg}) - (YAW_W+1)'(YAW_TURN))
                        : $signed({1'b0, yaw_reg});
    assign yaw_signed   = FIELD_W'(yaw_wide);
    assign pitch_signed = FIELD_W'(pitch_reg);
    assign done         = done_reg;

endmodule

`default_nettype wire

FILE: hdl/ypfv_cordic.sv
// ypfv_cordic: iterative rotation-mode cordic giving sine and cosine in q30
// of an angle in 1/128 degree, one micro-rotation a cycle. Depends on ypfv_pkg.
`default_nettype none

module ypfv_cordic
    import ypfv_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [FIELD_W-1:0] angle,
    output logic                           done,
    output sincos_t                        result
);

    localparam logic signed [FIELD_W:0] QT = (FIELD_W+1)'(QUARTER_TURN);
    localparam logic signed [FIELD_W:0] HT = (FIELD_W+1)'(HALF_TURN);

    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [CNT_W-1:0]     i_reg, i_next;
    logic                 flip_reg, flip_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic signed [FIELD_W:0] a_ext;
    logic signed [FIELD_W:0] a_red;
    logic                    a_flip;
    logic [4:0]              k;
    logic signed [CW-1:0]    xs, ys;
    logic signed [ZW-1:0]    at;

    // fold the angle into -90..90 degrees, negating the result outside
    always_comb
    begin
        a_ext  = (FIELD_W+1)'(angle);
        a_red  = a_ext;
        a_flip = 1'b0;
        if (a_ext > QT)
        begin
            a_red  = a_ext - HT;
            a_flip = 1'b1;
        end
        else if (a_ext < -QT)
        begin
            a_red  = a_ext + HT;
            a_flip = 1'b1;
        end
    end

    assign k  = 5'(i_reg);
    assign xs = x_reg >>> k;
    assign ys = y_reg >>> k;
    assign at = ZW'(atan_q16(k));

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = CW'(CORDIC_GAIN_Q30);
            y_next    = '0;
            z_next    = ZW'(a_red) <<< Z_SHIFT;
            i_next    = '0;
            flip_next = a_flip;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[ZW-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            if (i_reg == CNT_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                i_next = i_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg    <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            i_reg    <= i_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign result.sin_v = flip_reg ? -y_reg : y_reg;
    assign result.cos_v = flip_reg ? -x_reg : x_reg;
    assign done         = done_reg;

endmodule

`default_nettype wire

FILE: hdl/ypfv_prod.sv
// ypfv_prod: products of the pitch cosine with the yaw sine and cosine on one
// shared multiplier, then rounding and clamping of all three outputs.
// Depends on ypfv_pkg.
`default_nettype none

module ypfv_prod
    import ypfv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire sincos_t yaw_sc,
    input  wire sincos_t pitch_sc,
    output logic         done,
    output fwd_vec_t     fwd
);

    logic signed [CW-1:0]    cp_reg, cp_next;
    logic signed [CW-1:0]    sy_reg, sy_next;
    logic signed [CW-1:0]    cy_reg, cy_next;
    logic signed [MUL_W-1:0] prod_reg, prod_next;
    fwd_vec_t                fwd_reg, fwd_next;
    logic [2:0]              stage_reg, stage_next;
    logic                    done_reg, done_next;

    logic signed [CW-1:0]    mul_b;
    logic signed [MUL_W-1:0] mul_prod;

    assign mul_b    = stage_reg[0] ? sy_reg : cy_reg;
    assign mul_prod = cp_reg * mul_b;

    always_comb
    begin
        cp_next    = cp_reg;
        sy_next    = sy_reg;
        cy_next    = cy_reg;
        prod_next  = prod_reg;
        fwd_next   = fwd_reg;
        stage_next = {stage_reg[1:0], 1'b0};
        done_next  = 1'b0;
        if (start)
        begin
            cp_next        = pitch_sc.cos_v;
            sy_next        = yaw_sc.sin_v;
            cy_next        = yaw_sc.cos_v;
            fwd_next.fwd_y = round_clamp(MUL_W'(pitch_sc.sin_v), Q30_SHIFT);
            stage_next     = 3'b001;
        end
        if (stage_reg[0])
        begin
            prod_next = mul_prod;
        end
        if (stage_reg[1])
        begin
            fwd_next.fwd_x = round_clamp(prod_reg, Q60_SHIFT);
            prod_next      = mul_prod;
        end
        if (stage_reg[2])
        begin
            fwd_next.fwd_z = round_clamp(prod_reg, Q60_SHIFT);
            done_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg   <= cp_next;
        sy_reg   <= sy_next;
        cy_reg   <= cy_next;
        prod_reg <= prod_next;
        fwd_reg  <= fwd_next;
    end

    assign fwd  = fwd_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

FILE: hdl/yaw_pitch_forward_vector.sv
// yaw_pitch_forward_vector: top level with the request sequencer, gain
// register and output register. Uses ypfv_pkg, ypfv_angle, ypfv_cordic, ypfv_prod.
//
// Each accepted request adds its gain-scaled deltas to the stored yaw and
// pitch, wraps yaw to one turn, clamps pitch at 89 degrees and returns the
// forward unit vector in Q1.14. Between acceptance and a valid result the
// single cordic unit runs yaw and then pitch, after the yaw wrap and before
// the products on the shared multiplier. s_tready is high only between
// requests; a finished result waits in the output register while the next
// request is already taken in.
`default_nettype none

module yaw_pitch_forward_vector
    import ypfv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // delta_horizontal [15:0], delta_vertical [31:16]
    input  wire logic [2*FIELD_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // forward_x [15:0], forward_y [31:16], forward_z [47:32]
    output logic [3*FIELD_W-1:0]       m_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [GAIN_W-1:0]     cfg_wr_data
);

    state_t                state_reg, state_next;
    logic [GAIN_W-1:0]     gain_reg;
    sincos_t               yaw_sc_reg;
    fwd_vec_t              out_reg;
    logic                  m_tvalid_reg;

    logic                  accept;
    logic                  angle_start;
    logic                  angle_done;
    logic signed [FIELD_W-1:0] yaw_signed, pitch_signed;
    logic                  cor_start;
    logic signed [FIELD_W-1:0] cor_angle;
    logic                  cor_done;
    sincos_t               cor_result;
    logic                  prod_start;
    logic                  prod_done;
    fwd_vec_t              prod_fwd;
    logic                  out_load;

    assign accept = s_tvalid && s_tready;

    ypfv_angle u_angle (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (angle_start),
        .delta_horizontal (s_tdata[FIELD_W-1:0]),
        .delta_vertical   (s_tdata[2*FIELD_W-1:FIELD_W]),
        .rotation_gain    (gain_reg),
        .done             (angle_done),
        .yaw_signed       (yaw_signed),
        .pitch_signed     (pitch_signed)
    );

    ypfv_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cor_start),
        .angle  (cor_angle),
        .done   (cor_done),
        .result (cor_result)
    );

    ypfv_prod u_prod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (prod_start),
        .yaw_sc   (yaw_sc_reg),
        .pitch_sc (cor_result),
        .done     (prod_done),
        .fwd      (prod_fwd)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE:
            begin
                if (angle_done)
                begin
                    state_next = ST_COR_YAW;
                end
            end
            ST_COR_YAW:
            begin
                if (cor_done)
                begin
                    state_next = ST_COR_PITCH;
                end
            end
            ST_COR_PITCH:
            begin
                if (cor_done)
                begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                if (prod_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        angle_start = 1'b0;
        cor_start   = 1'b0;
        cor_angle   = pitch_signed;
        prod_start  = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                angle_start = s_tvalid;
            end
            ST_ANGLE:
            begin
                cor_start = angle_done;
                cor_angle = yaw_signed;
            end
            ST_COR_YAW:
            begin
                cor_start = cor_done;
            end
            ST_COR_PITCH:
            begin
                prod_start = cor_done;
            end
            ST_DONE:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            gain_reg     <= GAIN_W'(GAIN_RESET);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                gain_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COR_YAW && cor_done)
        begin
            yaw_sc_reg <= cor_result;
        end
        if (out_load)
        begin
            out_reg <= prod_fwd;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

`ifndef NO_ASSERTIONS
    // angle update finishes only while the sequencer waits for it
    a_angle_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        angle_done |-> state_reg == ST_ANGLE)
        else $error("angle update finished outside its phase");

    // the cordic reports only during one of its two runs
    a_cordic_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> (state_reg == ST_COR_YAW || state_reg == ST_COR_PITCH))
        else $error("cordic finished outside its runs");

    // products finish only while awaited
    a_prod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        prod_done |-> state_reg == ST_PROD)
        else $error("product unit finished outside its phase");

    // a held result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !out_load)
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
